// ----- sv/sha_pkg.sv -----
package sha_pkg;

  typedef logic [31:0] word_t;

  // Front-to-back queue entry: one message byte and/or an end marker.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } cmd_t;

  localparam int unsigned QueueDepth = 4;
  localparam logic [7:0]  PadMark    = 8'h80;
  localparam logic [5:0]  LenPos     = 6'd56;

  localparam word_t StartH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] t);
    word_t k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[t];
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- sv/sha_front.sv -----
module sha_front
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_has,
  input  logic       in_eom,
  output logic       q_valid,
  input  logic       q_ready,
  output cmd_t       q_data
);

  localparam int unsigned AW = $clog2(QueueDepth);

  cmd_t          mem [QueueDepth];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  // Drop idle words here; they never reach the back end.
  assign in_ready = (count != (AW+1)'(QueueDepth));
  assign push     = in_valid && in_ready && (in_has || in_eom);
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= '{data: in_byte, has_byte: in_has, eom: in_eom};
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ----- sv/sha_back.sv -----
module sha_back
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic [2:0]  out_index,
  output logic        out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROUND, S_FOLD, S_PAD, S_EMIT
  } state_t;

  state_t      state;
  word_t       blk [16];  // message block, big-endian bytes within each word
  logic [5:0]  fill;
  logic [63:0] len;
  word_t       hw [8];
  word_t       wv [8];
  word_t       win [16];
  logic [5:0]  rnd;
  logic        fin;       // finish pending after current block
  logic        len_done;  // pad mark written; once fin clears, the length block is the one being compressed
  logic [5:0]  ppos;
  logic [2:0]  oidx;

  word_t w_cur, s0, s1, t1, t2, x15, x2;

  always_comb begin
    x15 = win[4'(rnd - 6'd15)];
    x2  = win[4'(rnd - 6'd2)];
    s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    if (rnd < 6'd16) begin
      w_cur = blk[rnd[3:0]];
    end else begin
      w_cur = win[rnd[3:0]] + s0 + win[4'(rnd - 6'd7)] + s1;
    end
    t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25))
       + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + round_k(rnd) + w_cur;
    t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22))
       + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  assign q_ready   = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign out_word  = hw[oidx];
  assign out_index = oidx;
  assign out_last  = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      len   <= '0;
      fin   <= 1'b0;
      len_done <= 1'b0;
      oidx  <= '0;
      rnd   <= '0;
      ppos  <= '0;
      for (int i = 0; i < 8; i++) hw[i] <= StartH[i];
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          fin <= q_data.eom;
          len_done <= 1'b0;
          if (q_data.has_byte) begin
            blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= q_data.data;
            len  <= len + 64'd1;
            fill <= fill + 6'd1;
            if (fill == 6'd63) begin
              for (int i = 0; i < 8; i++) wv[i] <= hw[i];
              rnd   <= '0;
              state <= S_ROUND;
            end else if (q_data.eom) begin
              ppos  <= fill + 6'd1;
              state <= S_PAD;
            end
          end else if (q_data.eom) begin
            ppos  <= fill;
            state <= S_PAD;
          end
        end
        S_PAD: begin
          // Write 0x80 at the fill point, then zeros; length goes last.
          if (ppos == fill && !len_done) begin
            blk[ppos[5:2]][{~ppos[1:0], 3'b000} +: 8] <= PadMark;
            len_done  <= 1'b1;
          end else begin
            blk[ppos[5:2]][{~ppos[1:0], 3'b000} +: 8] <= 8'h00;
          end
          if (ppos == 6'd63) begin
            // Not enough room: compress the pad block, start a fresh one.
            for (int i = 0; i < 8; i++) wv[i] <= hw[i];
            rnd   <= '0;
            fill  <= '0;
            ppos  <= '0;
            state <= S_ROUND;
          end else if (ppos == LenPos - 6'd1 && (len_done || ppos == fill)) begin
            // Bit count, big-endian, in the last two words.
            blk[14] <= len[60:29];
            blk[15] <= {len[28:0], 3'b000};
            for (int i = 0; i < 8; i++) wv[i] <= hw[i];
            rnd   <= '0;
            fill  <= '0;
            ppos  <= '0;
            fin   <= 1'b0;
            state <= S_ROUND;
          end else begin
            ppos <= ppos + 6'd1;
          end
        end
        S_ROUND: begin
          win[rnd[3:0]] <= w_cur;
          wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
          wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) hw[i] <= hw[i] + wv[i];
          fill <= '0;
          if (fin) begin
            ppos  <= '0;
            state <= S_PAD;
          end else if (len_done) begin
            oidx  <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: if (out_ready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            for (int i = 0; i < 8; i++) hw[i] <= StartH[i];
            len      <= '0;
            fill     <= '0;
            len_done <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/sha256_message_digest_unit.sv -----
// SHA-256 engine, byte-streaming.
// s_axis: one word per message byte. tdata[7:0] = message_byte; tuser[0] = has_byte;
//   tlast = end_of_message. A word with has_byte 0 and tlast 0 is dropped.
// m_axis: eight digest words per message, tdata[31:0] = digest_word,
//   tuser[2:0] = word_index (0 most significant), tlast = last_word.
// Throughput: the back end takes a byte whenever it is idle; every 64th byte
//   starts a block compression (rounds, then a fold) that holds further bytes.
//   Finishing pads the block, runs one or two compressions, then emits eight words.
// A four-entry queue decouples input from the compression core, so bytes keep
//   being taken while a block is compressed until the queue fills.
// Reset (rst, synchronous, active high) empties the queue, loads the initial
//   hash values and clears the byte count.
// When m_axis_tready is low the current digest word holds and the core waits;
//   the queue still absorbs up to four byte or end-marker words.
module sha256_message_digest_unit
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] message_byte
  input  logic        s_axis_tuser,  // [0] has_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,  // [2:0] word_index
  output logic        m_axis_tlast
);

  logic q_valid;
  logic q_ready;
  cmd_t q_data;

  sha_front u_front (
    .clk, .rst,
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_has   (s_axis_tuser),
    .in_eom   (s_axis_tlast),
    .q_valid, .q_ready, .q_data
  );

  sha_back u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_data,
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (m_axis_tdata),
    .out_index (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

// ----- test/sha256_message_digest_unit_tb.sv -----
`timescale 1ns / 100ps

module sha256_message_digest_unit_tb;
  import sha_pkg::*;

  typedef struct {
    word_t      digest;
    logic [2:0] index;
    logic       last;
  } digest_word_t;

  // Hash predictor plus the queue of digest words still owed by the block.
  class digest_board;
    word_t        chain [8];
    logic [7:0]   block [64];
    int unsigned  fill;
    logic [63:0]  byte_count;
    digest_word_t owed [$];
    int           errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = StartH[i];
      fill = 0;
      byte_count = '0;
    endfunction

    function word_t ror(word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      word_t w [64];
      word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      word_t k [64];
      k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };
      for (int t = 0; t < 16; t++)
        w[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
      for (int t = 16; t < 64; t++) begin
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + k[t] + w[t];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Note one accepted input word; queue the digest when it ends a message.
    function void note_input(logic [7:0] data, logic has, logic eom);
      logic [63:0] bits;
      int unsigned pos;
      digest_word_t dw;
      if (has) begin
        block[fill] = data;
        fill++;
        byte_count++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (eom) begin
        bits = byte_count << 3;
        pos = fill;
        block[pos++] = PadMark;
        if (pos > LenPos) begin
          while (pos < 64) block[pos++] = 8'h00;
          compress();
          pos = 0;
        end
        while (pos < LenPos) block[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) block[63-i] = bits[8*i +: 8];
        compress();
        for (int i = 0; i < 8; i++) begin
          dw.digest = chain[i];
          dw.index = i[2:0];
          dw.last = (i == 7);
          owed.insert(owed.size(), dw);
        end
        restart();
      end
    endfunction

    // Compare one accepted digest word with the oldest owed one.
    function void check_output(word_t digest, logic [2:0] index, logic last);
      digest_word_t exp;
      if (owed.size() == 0) begin
        $display("%0t: unexpected digest word %h idx %0d last %0b",
                 $time, digest, index, last);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (digest !== exp.digest) begin
        $display("%0t: digest_word expected %h actual %h", $time, exp.digest, digest);
        errors++;
      end
      if (index !== exp.index) begin
        $display("%0t: word_index expected %0d actual %0d", $time, exp.index, index);
        errors++;
      end
      if (last !== exp.last) begin
        $display("%0t: last_word expected %0b actual %0b", $time, exp.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] message_byte
  logic        s_axis_tuser;   // [0] has_byte
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] digest_word
  logic [2:0]  m_axis_tuser;   // [2:0] word_index
  logic        m_axis_tlast;

  digest_board board;
  int          words_sent;
  bit          hold_sink;      // forces a long receiver stall

  sha256_message_digest_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pick a gap length: mostly zero or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(logic [7:0] data, logic has, logic eom);
    int gap;
    bit ready_seen;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= has;
    s_axis_tlast  <= eom;
    // Sample ready mid-cycle, where it holds its value for the next edge.
    forever begin
      @(negedge clk);
      ready_seen = s_axis_tready;
      @(posedge clk);
      if (ready_seen) break;
    end
    board.note_input(data, has, eom);
    words_sent++;
  endtask

  // Send a whole message of n random bytes; fold the last byte into the end
  // marker when asked.
  task automatic send_message(int n, bit fold_last);
    for (int i = 0; i < n; i++)
      send_word(8'($urandom_range(0, 255)), 1'b1, fold_last && (i == n - 1));
    if (!fold_last || n == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls; also check every accepted digest word.
  initial begin
    int stall;
    bit take;
    word_t dig;
    logic [2:0] idx;
    logic lst;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      take = m_axis_tvalid && m_axis_tready;
      dig  = m_axis_tdata;
      idx  = m_axis_tuser;
      lst  = m_axis_tlast;
      @(posedge clk);
      if (take)
        board.check_output(dig, idx, lst);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  // Sender and run control.
  initial begin
    int len;
    board = new();
    words_sent = 0;
    hold_sink = 1'b0;
    rst = 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, idle words, byte extremes, end with byte,
    // and the pad-boundary lengths (55/56 bytes, one full block).
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h5a, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'haa, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h55, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_message(55, 1'b1);
    send_message(56, 1'b1);
    send_message(64, 1'b0);
    send_message(63, 1'b0);

    // Pause the sender until every digest word is back.
    drain();

    // Long receiver stall while the sender keeps offering: block fills up.
    fork
      begin
        hold_sink = 1'b1;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end
      begin
        send_message(3, 1'b1);
        send_message(2, 1'b0);
        send_message(0, 1'b0);
        for (int i = 0; i < 6; i++) send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
    join
    send_word(8'h00, 1'b0, 1'b1);

    // Random messages: mostly short, some around the pad boundary.
    while (words_sent < 460) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(50, 70);
        1: len = 0;
        default: len = $urandom_range(1, 12);
      endcase
      if ($urandom_range(0, 7) == 0)
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_message(len, 1'($urandom_range(0, 1)));
    end

    drain();
    repeat (200) @(posedge clk);
    if (board.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sha_pkg.sv
sv/sha_front.sv
sv/sha_back.sv
sv/sha256_message_digest_unit.sv
test/sha256_message_digest_unit_tb.sv
